/* sv/edidbv_pkg.sv */
// ----------------------------------------------------------------------------
// EDID buffer validator package
// Buffer geometry, byte positions, mode codes and verdict codes shared by the
// validator modules.
// ----------------------------------------------------------------------------
package edidbv_pkg;

  localparam int MAX_BLOCKS  = 8;
  localparam int BLOCK_BYTES = 128;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int BLK_W       = $clog2(MAX_BLOCKS);
  localparam int POS_W       = BLK_W + OFF_W;
  localparam int TOTAL_BYTES = MAX_BLOCKS * BLOCK_BYTES;

  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(TOTAL_BYTES - 1);
  localparam logic [POS_W-1:0] POS_HDR_FIRST = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR_LAST  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_EXT_COUNT = POS_W'(8'h7e);
  localparam logic [POS_W-1:0] POS_EXT_TAG   = POS_W'(8'h80);
  localparam logic [OFF_W-1:0] OFF_LAST      = OFF_W'(BLOCK_BYTES - 1);

  localparam logic [7:0] HDR_FILL   = 8'hff;
  localparam logic [7:0] EXT_TAG_A  = 8'h02;
  localparam logic [7:0] EXT_TAG_B  = 8'hf0;
  localparam logic [7:0] STRICT_MIN = 8'd3;

  localparam logic [1:0] MODE_UNSET  = 2'd0;
  localparam logic [1:0] MODE_HDMI20 = 2'd1;
  localparam logic [1:0] MODE_HDMI21 = 2'd2;
  localparam logic [1:0] MODE_OTHER  = 2'd3;

  localparam logic [2:0] WHY_NONE     = 3'd0;
  localparam logic [2:0] WHY_UNSET    = 3'd1;
  localparam logic [2:0] WHY_HEADER   = 3'd2;
  localparam logic [2:0] WHY_CHECKSUM = 3'd3;
  localparam logic [2:0] WHY_ZERO_TAG = 3'd4;
  localparam logic [2:0] WHY_ALL_ZERO = 3'd5;
  localparam logic [2:0] WHY_STRICT   = 3'd6;

  typedef struct packed {
    logic       valid;
    logic       pass;
    logic [2:0] reason;
  } verdict_t;

endpackage

/* sv/edid_buffer_validator.sv */
// ----------------------------------------------------------------------------
// EDID buffer validator
// Checks a raw EDID buffer streamed one byte per request and returns one
// pass or fail verdict, with a reason, after the last byte of each buffer.
// ----------------------------------------------------------------------------
//  Channel  Handshake               Payload
//  input    in_valid / in_ready     edid_byte
//  output   out_valid / out_ready   edid_pass, fail_reason
//  config   cfg_write_en            cfg_write_data (version_mode)
//
//  One byte is accepted per cycle, except while the last byte of a buffer waits
//  on a full output register; a byte is registered, then folded into the
//  tracking state, and the verdict of a buffer is loaded into the output register.
//  Only the last byte of a buffer waits on a full output register; every
//  other byte flows on regardless of out_ready.
//  Synchronous reset clears the tracking state, the mode and both valid flags.
// ----------------------------------------------------------------------------
module edid_buffer_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] edid_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       edid_pass,
  output logic [2:0] fail_reason,
  input  logic       cfg_write_en,
  input  logic [1:0] cfg_write_data
);
  import edidbv_pkg::*;

  verdict_t verdict;
  logic     out_free;

  edidbv_track u_track (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .edid_byte      (edid_byte),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_free       (out_free),
    .verdict        (verdict)
  );

  edidbv_out u_out (
    .clk         (clk),
    .rst         (rst),
    .verdict     (verdict),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .edid_pass   (edid_pass),
    .fail_reason (fail_reason)
  );

endmodule

/* sv/edidbv_track.sv */
// ----------------------------------------------------------------------------
// EDID buffer tracker
// Registers each incoming byte, updates the per-buffer tracking state and
// forms the verdict when the last byte of a buffer is processed.
// ----------------------------------------------------------------------------
module edidbv_track (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             edid_byte,
  input  logic                   cfg_write_en,
  input  logic [1:0]             cfg_write_data,
  input  logic                   out_free,
  output edidbv_pkg::verdict_t   verdict
);
  import edidbv_pkg::*;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic [1:0]       version_mode;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       block_sum;
  logic [7:0]       extension_count;
  logic             base_header_ok;
  logic             ext_header_ok;
  logic             all_zero_so_far;
  logic [2:0]       first_failure;

  logic [7:0]       block_sum_next;
  logic [7:0]       extension_count_next;
  logic             base_header_ok_next;
  logic             ext_header_ok_next;
  logic             all_zero_so_far_next;
  logic [2:0]       first_failure_next;

  logic [BLK_W-1:0] blk;
  logic [OFF_W-1:0] off;
  logic             checked;
  logic             last;
  logic             go;
  logic [7:0]       sum_add;

  assign blk      = byte_position[POS_W-1:OFF_W];
  assign off      = byte_position[OFF_W-1:0];
  assign checked  = 8'(blk) <= extension_count;
  assign last     = byte_position == POS_LAST;
  assign go       = s1_valid && (!last || out_free);
  assign in_ready = !s1_valid || go;
  assign sum_add  = block_sum + s1_byte;

  always_comb begin
    all_zero_so_far_next = all_zero_so_far && (s1_byte == 8'h00);
    base_header_ok_next  = base_header_ok;
    extension_count_next = extension_count;
    ext_header_ok_next   = ext_header_ok;
    first_failure_next   = first_failure;
    block_sum_next       = sum_add;

    if (byte_position == POS_HDR_FIRST || byte_position == POS_HDR_LAST) begin
      if (s1_byte != 8'h00) begin
        base_header_ok_next = 1'b0;
      end
    end else if (byte_position < POS_HDR_LAST) begin
      if (s1_byte != HDR_FILL) begin
        base_header_ok_next = 1'b0;
      end
    end
    if (byte_position == POS_HDR_LAST && !base_header_ok_next &&
        first_failure_next == WHY_NONE) begin
      first_failure_next = WHY_HEADER;
    end

    if (byte_position == POS_EXT_COUNT) begin
      extension_count_next = s1_byte;
    end
    if (byte_position == POS_EXT_TAG) begin
      ext_header_ok_next = s1_byte inside {EXT_TAG_A, EXT_TAG_B};
    end

    if (off == '0 && blk != '0 && checked && s1_byte == 8'h00 &&
        first_failure_next == WHY_NONE) begin
      first_failure_next = WHY_ZERO_TAG;
    end

    if (off == OFF_LAST) begin
      if (checked && sum_add != 8'h00 && first_failure_next == WHY_NONE) begin
        first_failure_next = WHY_CHECKSUM;
      end
      block_sum_next = 8'h00;
    end
  end

  always_comb begin
    verdict.valid  = go && last;
    verdict.pass   = 1'b1;
    verdict.reason = WHY_NONE;
    case (version_mode)
      MODE_UNSET: begin
        verdict.pass   = 1'b0;
        verdict.reason = WHY_UNSET;
      end
      MODE_HDMI20: begin
        if (first_failure_next != WHY_NONE) begin
          verdict.pass   = 1'b0;
          verdict.reason = first_failure_next;
        end
      end
      MODE_HDMI21: begin
        if (all_zero_so_far_next) begin
          verdict.pass   = 1'b0;
          verdict.reason = WHY_ALL_ZERO;
        end else if (extension_count_next > STRICT_MIN && !base_header_ok_next &&
                     !ext_header_ok_next) begin
          verdict.pass   = 1'b0;
          verdict.reason = WHY_STRICT;
        end
      end
      default: begin
        verdict.pass   = 1'b1;
        verdict.reason = WHY_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_byte <= edid_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      version_mode    <= MODE_UNSET;
      byte_position   <= '0;
      block_sum       <= 8'h00;
      extension_count <= 8'h00;
      base_header_ok  <= 1'b1;
      ext_header_ok   <= 1'b0;
      all_zero_so_far <= 1'b1;
      first_failure   <= WHY_NONE;
    end else begin
      if (cfg_write_en) begin
        version_mode <= cfg_write_data;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (go) begin
        if (last) begin
          byte_position   <= '0;
          block_sum       <= 8'h00;
          extension_count <= 8'h00;
          base_header_ok  <= 1'b1;
          ext_header_ok   <= 1'b0;
          all_zero_so_far <= 1'b1;
          first_failure   <= WHY_NONE;
        end else begin
          byte_position   <= byte_position + 1'b1;
          block_sum       <= block_sum_next;
          extension_count <= extension_count_next;
          base_header_ok  <= base_header_ok_next;
          ext_header_ok   <= ext_header_ok_next;
          all_zero_so_far <= all_zero_so_far_next;
          first_failure   <= first_failure_next;
        end
      end
    end
  end

  a_sum_clear_at_block_start: assert property (@(posedge clk) disable iff (rst)
    off == '0 |-> block_sum == 8'h00)
    else $error("block sum not cleared at the start of a block");

  a_failure_code_legal: assert property (@(posedge clk) disable iff (rst)
    first_failure == WHY_NONE || first_failure == WHY_HEADER ||
    first_failure == WHY_CHECKSUM || first_failure == WHY_ZERO_TAG)
    else $error("recorded failure has an impossible code");

  a_failure_sticky: assert property (@(posedge clk) disable iff (rst)
    (first_failure != WHY_NONE && !(go && last)) |=> first_failure == $past(first_failure))
    else $error("first failure overwritten within a buffer");

  a_header_failure_after_header: assert property (@(posedge clk) disable iff (rst)
    first_failure == WHY_HEADER |-> byte_position > POS_HDR_LAST)
    else $error("header failure recorded before the header was complete");

endmodule

/* sv/edidbv_out.sv */
// ----------------------------------------------------------------------------
// EDID verdict output register
// Holds one verdict until it is taken, and frees itself in the same cycle as
// the verdict leaves.
// ----------------------------------------------------------------------------
module edidbv_out (
  input  logic                 clk,
  input  logic                 rst,
  input  edidbv_pkg::verdict_t verdict,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 edid_pass,
  output logic [2:0]           fail_reason
);
  import edidbv_pkg::*;

  logic load;

  assign out_free = !out_valid || out_ready;
  assign load     = verdict.valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= verdict.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      edid_pass   <= verdict.pass;
      fail_reason <= verdict.reason;
    end
  end

  a_verdict_not_dropped: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> out_free)
    else $error("verdict offered while the output register is full");

  a_pass_means_no_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (edid_pass == (fail_reason == WHY_NONE)))
    else $error("pass flag and reason disagree");

  a_held_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(fail_reason) && $stable(edid_pass))
    else $error("stalled verdict changed");

endmodule

/* tb/edid_buffer_validator_test.sv */
// ----------------------------------------------------------------------------
// EDID buffer validator testbench
// Streams whole EDID buffers into the validator under every version mode and
// predicts each verdict from the bytes as they are accepted. Directed buffers
// cover the header, checksum, extension tag, all-zero and strict header cases,
// and random buffers follow, mostly well formed and partly damaged. The sender
// works in bursts and the receiver stalls, and every verdict is checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module edid_buffer_validator_test;
  import edidbv_pkg::*;

  localparam int LIMIT = 3_000_000;

  typedef struct packed {
    logic       pass;
    logic [2:0] reason;
  } expected_t;

  typedef enum int {
    DMG_NONE, DMG_HEADER, DMG_SUM, DMG_TAG, DMG_ZERO, DMG_NOISE, DMG_STRICT
  } damage_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] edid_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       edid_pass;
  logic [2:0] fail_reason;
  logic       cfg_write_en = 1'b0;
  logic [1:0] cfg_write_data = MODE_UNSET;

  logic [7:0] image [TOTAL_BYTES];
  expected_t  pending_verdicts [$];
  int         failures = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  bit         sender_calm = 1'b0;
  int         stall_kind = 0;
  int         stall_left = 0;

  logic [1:0] mode_now = MODE_UNSET;
  int         track_pos;
  logic [7:0] track_sum;
  logic [7:0] track_count;
  logic       base_hdr_good;
  logic       ext_hdr_good;
  logic       all_zero_seen;
  logic [2:0] first_fault;

  edid_buffer_validator u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .edid_byte      (edid_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .edid_pass      (edid_pass),
    .fail_reason    (fail_reason),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver switches between stall patterns, including a long hold that
  // keeps a verdict waiting until the next buffer is complete.
  always @(negedge clk) begin
    int r;
    if (stall_left == 0) begin
      r = $urandom_range(0, 15);
      stall_kind = (r < 4) ? 0 : (r < 8) ? 1 : (r < 12) ? 2 : (r < 15) ? 3 : 4;
      stall_left = (stall_kind == 4) ? $urandom_range(1100, 1600) : $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_kind)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) != 0);
      3: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    expected_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict with no buffer outstanding: edid_pass %0d, fail_reason %0d",
               edid_pass, fail_reason);
        failures++;
      end else begin
        want = pending_verdicts.pop_front();
        if (edid_pass !== want.pass) begin
          $error("edid_pass mismatch: expected %0d, actual %0d", want.pass, edid_pass);
          failures++;
        end
        if (fail_reason !== want.reason) begin
          $error("fail_reason mismatch: expected %0d, actual %0d", want.reason, fail_reason);
          failures++;
        end
      end
    end
  end

  function automatic void clear_tracking();
    track_pos     = 0;
    track_sum     = 8'h00;
    track_count   = 8'h00;
    base_hdr_good = 1'b1;
    ext_hdr_good  = 1'b0;
    all_zero_seen = 1'b1;
    first_fault   = WHY_NONE;
  endfunction

  function automatic void note_fault(input logic [2:0] why);
    if (first_fault == WHY_NONE) first_fault = why;
  endfunction

  function automatic void fold_byte(input logic [7:0] b);
    int        blk;
    int        off;
    logic      checked;
    expected_t v;
    blk = track_pos / BLOCK_BYTES;
    off = track_pos % BLOCK_BYTES;
    checked = (blk <= track_count);
    if (b != 8'h00) all_zero_seen = 1'b0;
    if (track_pos == POS_HDR_FIRST || track_pos == POS_HDR_LAST) begin
      if (b != 8'h00) base_hdr_good = 1'b0;
    end else if (track_pos < POS_HDR_LAST) begin
      if (b != HDR_FILL) base_hdr_good = 1'b0;
    end
    if (track_pos == POS_HDR_LAST && !base_hdr_good) note_fault(WHY_HEADER);
    if (track_pos == POS_EXT_COUNT) track_count = b;
    if (track_pos == POS_EXT_TAG) ext_hdr_good = (b == EXT_TAG_A || b == EXT_TAG_B);
    if (off == 0 && blk >= 1 && checked && b == 8'h00) note_fault(WHY_ZERO_TAG);
    track_sum = track_sum + b;
    if (off == OFF_LAST) begin
      if (checked && track_sum != 8'h00) note_fault(WHY_CHECKSUM);
      track_sum = 8'h00;
    end
    if (track_pos != POS_LAST) begin
      track_pos++;
    end else begin
      v.pass = 1'b1;
      v.reason = WHY_NONE;
      case (mode_now)
        MODE_UNSET: begin
          v.pass = 1'b0;
          v.reason = WHY_UNSET;
        end
        MODE_HDMI20: begin
          if (first_fault != WHY_NONE) begin
            v.pass = 1'b0;
            v.reason = first_fault;
          end
        end
        MODE_HDMI21: begin
          if (all_zero_seen) begin
            v.pass = 1'b0;
            v.reason = WHY_ALL_ZERO;
          end else if (track_count > STRICT_MIN && !base_hdr_good && !ext_hdr_good) begin
            v.pass = 1'b0;
            v.reason = WHY_STRICT;
          end
        end
        default: ;
      endcase
      pending_verdicts.push_back(v);
      clear_tracking();
    end
  endfunction

  function automatic void seal(input int blk);
    logic [7:0] s = 8'h00;
    for (int i = 0; i < BLOCK_BYTES - 1; i++) s += image[blk * BLOCK_BYTES + i];
    image[blk * BLOCK_BYTES + BLOCK_BYTES - 1] = -s;
  endfunction

  function automatic void make_good(input int count);
    for (int i = 0; i < TOTAL_BYTES; i++) image[i] = 8'($urandom);
    image[POS_HDR_FIRST] = 8'h00;
    image[POS_HDR_LAST] = 8'h00;
    for (int i = 1; i < 7; i++) image[i] = HDR_FILL;
    image[POS_EXT_COUNT] = 8'(count);
    for (int b = 1; b < MAX_BLOCKS; b++) begin
      if (image[b * BLOCK_BYTES] == 8'h00) image[b * BLOCK_BYTES] = EXT_TAG_A;
    end
    for (int b = 0; b < MAX_BLOCKS; b++) seal(b);
  endfunction

  function automatic void fill_image(input logic [7:0] value);
    for (int i = 0; i < TOTAL_BYTES; i++) image[i] = value;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = (sender_calm || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 64);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    edid_byte <= b;
    do @(posedge clk); while (!in_ready);
    fold_byte(b);
  endtask

  task automatic send_range(input int first, input int last);
    for (int i = first; i <= last; i++) send_byte(image[i]);
  endtask

  task automatic send_image();
    send_range(0, TOTAL_BYTES - 1);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_idle();
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= m;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    mode_now = m;
  endtask

  task automatic test_unset_mode();
    make_good(1);
    send_image();
    fill_image(8'h00);
    send_image();
  endtask

  task automatic test_hdmi20_checks();
    set_mode(MODE_HDMI20);
    make_good(7);
    send_image();
    make_good(0);
    image[BLOCK_BYTES] = 8'h00;
    image[3 * BLOCK_BYTES + 9] += 8'h01;
    send_image();
    make_good(255);
    send_image();
    make_good(1);
    image[POS_HDR_FIRST] = 8'h01;
    seal(0);
    send_image();
    make_good(1);
    image[POS_HDR_LAST] = 8'hff;
    seal(0);
    send_image();
    make_good(1);
    image[3] = 8'h00;
    send_image();
    make_good(2);
    image[40] += 8'h01;
    send_image();
    make_good(5);
    image[3 * BLOCK_BYTES] = 8'h00;
    seal(3);
    send_image();
    make_good(7);
    image[7 * BLOCK_BYTES + 5] += 8'h01;
    send_image();
    make_good(3);
    image[BLOCK_BYTES + 9] += 8'h01;
    image[2 * BLOCK_BYTES] = 8'h00;
    seal(2);
    send_image();
    make_good(2);
    image[3 * BLOCK_BYTES] = 8'h00;
    image[4 * BLOCK_BYTES + 7] += 8'h01;
    send_image();
  endtask

  task automatic test_hdmi21_checks();
    set_mode(MODE_HDMI21);
    fill_image(8'h00);
    send_image();
    make_good(4);
    image[POS_HDR_FIRST] = 8'h01;
    image[POS_EXT_TAG] = 8'h00;
    seal(0);
    seal(1);
    send_image();
    image[POS_EXT_TAG] = EXT_TAG_A;
    send_image();
    image[POS_EXT_TAG] = EXT_TAG_B;
    send_image();
    make_good(3);
    image[5] = 8'h00;
    image[POS_EXT_TAG] = 8'h00;
    send_image();
    make_good(255);
    image[POS_EXT_TAG] = 8'hff;
    send_image();
    image[POS_HDR_LAST] = 8'hff;
    send_image();
  endtask

  task automatic test_other_mode();
    set_mode(MODE_OTHER);
    fill_image(8'h00);
    send_image();
    fill_image(8'hff);
    send_image();
  endtask

  task automatic test_mode_change_mid_buffer();
    set_mode(MODE_HDMI20);
    make_good(1);
    image[2] = 8'h00;
    seal(0);
    send_range(0, TOTAL_BYTES / 2 - 1);
    set_mode(MODE_OTHER);
    send_range(TOTAL_BYTES / 2, TOTAL_BYTES - 1);
    set_mode(MODE_HDMI21);
    make_good(2);
    send_range(0, 300);
    set_mode(MODE_UNSET);
    send_range(301, TOTAL_BYTES - 1);
  endtask

  task automatic test_random_buffers();
    damage_t dmg;
    int      blk;
    for (int n = 0; n < 40; n++) begin
      if (n % 3 == 0) set_mode(2'($urandom_range(0, 3)));
      sender_calm = ($urandom_range(0, 4) == 0);
      make_good(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) begin
        image[POS_EXT_TAG] = 8'($urandom);
        seal(1);
      end
      dmg = damage_t'(($urandom_range(0, 12) > 6) ? $urandom_range(1, 6) : 0);
      case (dmg)
        DMG_HEADER: begin
          image[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
          if ($urandom_range(0, 1) == 1) seal(0);
        end
        DMG_SUM: begin
          blk = $urandom_range(0, MAX_BLOCKS - 1);
          image[blk * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES - 1)] +=
            8'($urandom_range(1, 255));
        end
        DMG_TAG: begin
          blk = $urandom_range(1, MAX_BLOCKS - 1);
          image[blk * BLOCK_BYTES] = 8'h00;
          seal(blk);
        end
        DMG_ZERO: fill_image(8'h00);
        DMG_NOISE: for (int i = 0; i < TOTAL_BYTES; i++) image[i] = 8'($urandom);
        DMG_STRICT: begin
          image[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
          image[POS_EXT_COUNT] = 8'($urandom_range(4, 255));
          image[POS_EXT_TAG] = 8'($urandom);
          seal(0);
          seal(1);
        end
        default: ;
      endcase
      send_image();
    end
    sender_calm = 1'b0;
  endtask

  initial begin
    clear_tracking();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_unset_mode();
    test_hdmi20_checks();
    test_hdmi21_checks();
    test_other_mode();
    test_mode_change_mid_buffer();
    test_random_buffers();
    wait_idle();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/edidbv_pkg.sv
sv/edidbv_track.sv
sv/edidbv_out.sv
sv/edid_buffer_validator.sv
tb/edid_buffer_validator_test.sv
